FILE: hw/rtl/mas_pkg.sv
// shared types, constants and the remainder step of the modular arithmetic unit
`default_nettype none

package mas_pkg;

	localparam int VALUE_BITS = 31;
	localparam int LHS_BITS   = 32;
	localparam int NUM_BITS   = (VALUE_BITS > LHS_BITS) ? VALUE_BITS : LHS_BITS;
	localparam int PROD_BITS  = 2 * VALUE_BITS;

	localparam logic [VALUE_BITS-1:0] DEFAULT_MOD = VALUE_BITS'(64'd1000000007);

	typedef logic [VALUE_BITS-1:0] val_t;

	typedef enum logic [1:0] {
		CMD_REDUCE = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_SUB    = 2'd2,
		CMD_MUL    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_ZERO_MOD = 2'd2
	} status_t;

	typedef struct packed {
		logic    valid;
		cmd_t    cmd;
		logic    neg;
		status_t status;
	} ctrl_t;

	// one bit of restoring remainder: shift in a bit, subtract the modulus if it fits
	function automatic val_t rem_step(val_t r, logic b, val_t m);
		logic [VALUE_BITS:0] t;
		t = {r, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[VALUE_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/modular_add_sub_mul_unit.sv
// throughput: one request every cycle; busy stays low, the unit never stalls
// the pipeline holds the 32 one-bit remainder stages of the operands and the
// 31 one-bit remainder stages of the product, plus input, operation and output stages
// arst_n clears every valid bit; requests in flight at reset are dropped
`default_nettype none

module modular_add_sub_mul_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           cmd,
	input  wire logic signed [31:0]   lhs_value,
	input  wire mas_pkg::val_t        lhs_mod,
	input  wire mas_pkg::val_t        rhs_value,
	input  wire mas_pkg::val_t        rhs_mod,
	output logic                      done,
	output mas_pkg::val_t             res_value,
	output mas_pkg::val_t             res_mod,
	output logic [1:0]                status
);
	import mas_pkg::*;

	cmd_t                cmd_in;
	logic                is_reduce;
	logic                neg;
	logic [LHS_BITS-1:0] lhs_bits;
	logic [LHS_BITS-1:0] mag;
	ctrl_t               ctrl_in;

	ctrl_t               ctrl_s1;
	logic [NUM_BITS-1:0] num_a_s1;
	logic [NUM_BITS-1:0] num_b_s1;
	val_t                mod_s1;

	ctrl_t               red_ctrl;
	val_t                red_rem_a;
	val_t                red_rem_b;
	val_t                red_mod;

	ctrl_t               fin_ctrl;
	val_t                fin_val;
	val_t                fin_mod;

	assign busy = 1'b0;

	always_comb begin
		cmd_in    = cmd_t'(cmd);
		is_reduce = (cmd_in == CMD_REDUCE);
		lhs_bits  = lhs_value;
		neg       = is_reduce && lhs_bits[LHS_BITS-1];
		mag       = neg ? (LHS_BITS'(0) - lhs_bits) : lhs_bits;
		ctrl_in.valid = start;
		ctrl_in.cmd   = cmd_in;
		ctrl_in.neg   = neg;
		if (!is_reduce && (lhs_mod != rhs_mod)) begin
			ctrl_in.status = ST_MISMATCH;
		end else if (lhs_mod == '0) begin
			ctrl_in.status = ST_ZERO_MOD;
		end else begin
			ctrl_in.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		num_a_s1 <= NUM_BITS'(mag);
		num_b_s1 <= NUM_BITS'(rhs_value);
		mod_s1   <= lhs_mod;
	end

	mas_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_in   (ctrl_s1),
		.num_a_in  (num_a_s1),
		.num_b_in  (num_b_s1),
		.mod_in    (mod_s1),
		.ctrl_out  (red_ctrl),
		.rem_a_out (red_rem_a),
		.rem_b_out (red_rem_b),
		.mod_out   (red_mod)
	);

	mas_mulred u_mulred (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (red_ctrl),
		.rem_a_in (red_rem_a),
		.rem_b_in (red_rem_b),
		.mod_in   (red_mod),
		.ctrl_out (fin_ctrl),
		.val_out  (fin_val),
		.mod_out  (fin_mod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin_ctrl.valid;
		end
	end

	// flagged requests return zero, with the default modulus on a mismatch
	always_ff @(posedge clk) begin
		status <= fin_ctrl.status;
		unique case (fin_ctrl.status)
			ST_OK: begin
				res_value <= fin_val;
				res_mod   <= fin_mod;
			end
			ST_MISMATCH: begin
				res_value <= '0;
				res_mod   <= DEFAULT_MOD;
			end
			default: begin
				res_value <= '0;
				res_mod   <= '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mas_reduce.sv
// bit-serial pipelined remainder of both operands by the modulus
`default_nettype none

module mas_reduce (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire mas_pkg::ctrl_t                 ctrl_in,
	input  wire logic [mas_pkg::NUM_BITS-1:0]   num_a_in,
	input  wire logic [mas_pkg::NUM_BITS-1:0]   num_b_in,
	input  wire mas_pkg::val_t                  mod_in,
	output mas_pkg::ctrl_t                      ctrl_out,
	output mas_pkg::val_t                       rem_a_out,
	output mas_pkg::val_t                       rem_b_out,
	output mas_pkg::val_t                       mod_out
);
	import mas_pkg::*;

	ctrl_t               ctrl_s  [1:NUM_BITS];
	logic [NUM_BITS-1:0] num_a_s [1:NUM_BITS];
	logic [NUM_BITS-1:0] num_b_s [1:NUM_BITS];
	val_t                rem_a_s [1:NUM_BITS];
	val_t                rem_b_s [1:NUM_BITS];
	val_t                mod_s   [1:NUM_BITS];

	genvar k;
	for (k = 0; k < NUM_BITS; k++) begin : g_stage
		ctrl_t               c_in;
		logic [NUM_BITS-1:0] na_in;
		logic [NUM_BITS-1:0] nb_in;
		val_t                ra_in;
		val_t                rb_in;
		val_t                m_in;

		if (k == 0) begin : g_src_first
			assign c_in  = ctrl_in;
			assign na_in = num_a_in;
			assign nb_in = num_b_in;
			assign ra_in = '0;
			assign rb_in = '0;
			assign m_in  = mod_in;
		end else begin : g_src_next
			assign c_in  = ctrl_s[k];
			assign na_in = num_a_s[k];
			assign nb_in = num_b_s[k];
			assign ra_in = rem_a_s[k];
			assign rb_in = rem_b_s[k];
			assign m_in  = mod_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctrl_s[k+1] <= '0;
			end else begin
				ctrl_s[k+1] <= c_in;
			end
		end

		// top bit of each number goes into its remainder
		always_ff @(posedge clk) begin
			num_a_s[k+1] <= na_in << 1;
			num_b_s[k+1] <= nb_in << 1;
			rem_a_s[k+1] <= rem_step(ra_in, na_in[NUM_BITS-1], m_in);
			rem_b_s[k+1] <= rem_step(rb_in, nb_in[NUM_BITS-1], m_in);
			mod_s[k+1]   <= m_in;
		end
	end

	assign ctrl_out  = ctrl_s[NUM_BITS];
	assign rem_a_out = rem_a_s[NUM_BITS];
	assign rem_b_out = rem_b_s[NUM_BITS];
	assign mod_out   = mod_s[NUM_BITS];

endmodule

`default_nettype wire

FILE: hw/rtl/mas_mulred.sv
// operation stage and pipelined reduction of the double-width product
`default_nettype none

module mas_mulred (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mas_pkg::ctrl_t ctrl_in,
	input  wire mas_pkg::val_t  rem_a_in,
	input  wire mas_pkg::val_t  rem_b_in,
	input  wire mas_pkg::val_t  mod_in,
	output mas_pkg::ctrl_t      ctrl_out,
	output mas_pkg::val_t       val_out,
	output mas_pkg::val_t       mod_out
);
	import mas_pkg::*;

	ctrl_t ctrl_s [0:VALUE_BITS];
	val_t  val_s  [0:VALUE_BITS];
	val_t  low_s  [0:VALUE_BITS];
	val_t  mod_s  [0:VALUE_BITS];

	logic [VALUE_BITS:0]  sum;
	logic [VALUE_BITS:0]  diff;
	logic [PROD_BITS-1:0] prod;
	val_t                 op_val;
	val_t                 op_low;

	always_comb begin
		sum    = {1'b0, rem_a_in} + {1'b0, rem_b_in};
		diff   = {1'b0, rem_a_in} - {1'b0, rem_b_in};
		prod   = PROD_BITS'(rem_a_in) * PROD_BITS'(rem_b_in);
		op_low = prod[VALUE_BITS-1:0];
		unique case (ctrl_in.cmd)
			CMD_REDUCE: begin
				// negative input: fold a non-zero remainder back from the modulus
				op_val = (ctrl_in.neg && (rem_a_in != '0)) ? (mod_in - rem_a_in) : rem_a_in;
			end
			CMD_ADD: begin
				op_val = (sum >= {1'b0, mod_in}) ? VALUE_BITS'(sum - {1'b0, mod_in})
					: sum[VALUE_BITS-1:0];
			end
			CMD_SUB: begin
				op_val = diff[VALUE_BITS] ? VALUE_BITS'(diff + {1'b0, mod_in})
					: diff[VALUE_BITS-1:0];
			end
			CMD_MUL: begin
				// high half is already below the modulus since both factors are
				op_val = prod[PROD_BITS-1:VALUE_BITS];
			end
			default: begin
				op_val = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s[0] <= '0;
		end else begin
			ctrl_s[0] <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		val_s[0] <= op_val;
		low_s[0] <= op_low;
		mod_s[0] <= mod_in;
	end

	genvar k;
	for (k = 0; k < VALUE_BITS; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctrl_s[k+1] <= '0;
			end else begin
				ctrl_s[k+1] <= ctrl_s[k];
			end
		end

		// only a product walks its low half in, other results pass unchanged
		always_ff @(posedge clk) begin
			if (ctrl_s[k].cmd == CMD_MUL) begin
				val_s[k+1] <= rem_step(val_s[k], low_s[k][VALUE_BITS-1], mod_s[k]);
			end else begin
				val_s[k+1] <= val_s[k];
			end
			low_s[k+1] <= low_s[k] << 1;
			mod_s[k+1] <= mod_s[k];
		end
	end

	assign ctrl_out = ctrl_s[VALUE_BITS];
	assign val_out  = val_s[VALUE_BITS];
	assign mod_out  = mod_s[VALUE_BITS];

endmodule

`default_nettype wire

FILE: bench/tb_modular_add_sub_mul_unit.sv
// testbench for the modular add, subtract and multiply unit, with a scoreboard and random requests
`default_nettype none

module tb_modular_add_sub_mul_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mas_pkg::*;

	localparam int  CYCLE_LIMIT   = 100000;
	localparam int  DRAIN_CYCLES  = 80;
	localparam int  RANDOM_ITEMS  = 1550;
	localparam val_t MAX_MOD      = 31'h7fffffff;

	class mas_scoreboard;
		typedef struct {
			val_t    value;
			val_t    modulus;
			status_t st;
		} outcome_t;

		outcome_t    awaited_results[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function outcome_t modular_result(cmd_t c, logic signed [31:0] lv, val_t lm,
				val_t rv, val_t rm);
			outcome_t    o;
			logic [63:0] m;
			logic [63:0] mag;
			logic [63:0] a;
			logic [63:0] b;
			logic [63:0] r;
			m = {33'b0, lm};
			o.value = '0;
			o.modulus = lm;
			o.st = ST_OK;
			// a mismatch wins over a zero modulus
			if (c != CMD_REDUCE && lm != rm) begin
				o.modulus = DEFAULT_MOD;
				o.st = ST_MISMATCH;
			end else if (lm == 0) begin
				o.modulus = '0;
				o.st = ST_ZERO_MOD;
			end else if (c == CMD_REDUCE) begin
				if (lv[31]) begin
					mag = 64'h1_0000_0000 - {32'b0, lv};
				end else begin
					mag = {32'b0, lv};
				end
				r = mag % m;
				if (lv[31] && r != 0) begin
					r = m - r;
				end
				o.value = r[30:0];
			end else begin
				// left value is taken as unsigned for the two-operand commands
				a = {32'b0, lv} % m;
				b = {33'b0, rv} % m;
				case (c)
					CMD_ADD: begin
						r = (a + b) % m;
					end
					CMD_SUB: begin
						r = (a + m - b) % m;
					end
					default: begin
						r = (a * b) % m;
					end
				endcase
				o.value = r[30:0];
			end
			return o;
		endfunction

		function void note_request(cmd_t c, logic signed [31:0] lv, val_t lm, val_t rv,
				val_t rm);
			awaited_results.push_back(modular_result(c, lv, lm, rv, rm));
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(val_t v, val_t m, logic [1:0] s);
			outcome_t o;
			if (awaited_results.size() == 0) begin
				report($sformatf("result %0d/%0d/%0d with no request outstanding", v, m, s));
			end else begin
				o = awaited_results.pop_front();
				if (v !== o.value) begin
					report($sformatf("res_value %0d, wanted %0d", v, o.value));
				end
				if (m !== o.modulus) begin
					report($sformatf("res_mod %0d, wanted %0d", m, o.modulus));
				end
				if (s !== o.st) begin
					report($sformatf("status %0d, wanted %0d", s, o.st));
				end
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        cmd;
	logic signed [31:0] lhs_value;
	val_t              lhs_mod;
	val_t              rhs_value;
	val_t              rhs_mod;
	logic              done;
	val_t              res_value;
	val_t              res_mod;
	logic [1:0]        status;

	mas_scoreboard sb;
	int unsigned   cycles;
	bit            idling_allowed;

	modular_add_sub_mul_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.lhs_value (lhs_value),
		.lhs_mod   (lhs_mod),
		.rhs_value (rhs_value),
		.rhs_mod   (rhs_mod),
		.done      (done),
		.res_value (res_value),
		.res_mod   (res_mod),
		.status    (status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[modular_add_sub_mul_unit] ERROR");
			$finish;
		end
	end

	// values seen here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_request(cmd_t'(cmd), lhs_value, lhs_mod, rhs_value, rhs_mod);
		end
		if (done) begin
			sb.check_result(res_value, res_mod, status);
		end
	end

	// called at a rising edge; returns at the edge that takes the request
	task send_request(cmd_t c, logic signed [31:0] lv, val_t lm, val_t rv, val_t rm);
		if (idling_allowed && $urandom_range(99) < 19) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 19) begin
				@(posedge clk);
			end
		end
		start     <= 1'b1;
		cmd       <= c;
		lhs_value <= lv;
		lhs_mod   <= lm;
		rhs_value <= rv;
		rhs_mod   <= rm;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	task drain_results();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
	endtask

	initial begin
		int unsigned       kind;
		cmd_t              c;
		logic signed [31:0] lv;
		val_t              m;
		val_t              rm;
		val_t              rv;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_REDUCE;
		lhs_value = '0;
		lhs_mod = '0;
		rhs_value = '0;
		rhs_mod = '0;
		cycles = 0;
		idling_allowed = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reduce: extremes of the signed value, negative multiples, modulus of one
		send_request(CMD_REDUCE, 32'sh80000000, 31'd1, '0, '0);
		send_request(CMD_REDUCE, 32'sh80000000, MAX_MOD, MAX_MOD, 31'd3);
		send_request(CMD_REDUCE, 32'sh7fffffff, MAX_MOD, '0, '0);
		send_request(CMD_REDUCE, -32'sd1, 31'd7, '0, '0);
		send_request(CMD_REDUCE, -32'sd14, 31'd7, '0, '0);
		send_request(CMD_REDUCE, 32'sd0, 31'd5, '0, '0);
		send_request(CMD_REDUCE, 32'sd123, 31'd0, '0, 31'd9);
		// two-operand commands at the top of the range and with small moduli
		send_request(CMD_ADD, 32'sd2147483646, MAX_MOD, 31'd2147483646, MAX_MOD);
		send_request(CMD_SUB, 32'sd3, MAX_MOD, 31'd2147483646, MAX_MOD);
		send_request(CMD_SUB, 32'sd9, 31'd10, 31'd9, 31'd10);
		send_request(CMD_MUL, 32'sd2147483646, MAX_MOD, 31'd2147483646, MAX_MOD);
		send_request(CMD_MUL, 32'sd5, 31'd1, 31'd7, 31'd1);
		// unreduced operands
		send_request(CMD_ADD, 32'shffffffff, 31'd1000, MAX_MOD, 31'd1000);
		send_request(CMD_SUB, 32'shffffffff, 31'd1000, MAX_MOD, 31'd1000);
		send_request(CMD_MUL, 32'shffffffff, 31'd1000000007, MAX_MOD, 31'd1000000007);
		// moduli that differ, including a zero on one side only
		send_request(CMD_ADD, 32'sd1, 31'd5, 31'd1, 31'd6);
		send_request(CMD_SUB, 32'sd1, 31'd0, 31'd1, 31'd5);
		send_request(CMD_MUL, 32'sd1, 31'd5, 31'd1, 31'd0);
		// zero modulus on both sides
		send_request(CMD_ADD, 32'sd4, 31'd0, 31'd4, 31'd0);
		send_request(CMD_SUB, 32'sd4, 31'd0, 31'd4, 31'd0);
		send_request(CMD_MUL, 32'shffffffff, 31'd0, MAX_MOD, 31'd0);
		drain_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idling_allowed = !(i >= 500 && i < 800);
			if (i == 1000) begin
				drain_results();
			end
			kind = $urandom_range(99);
			c = cmd_t'($urandom_range(3));
			case ($urandom_range(3))
				0: m = val_t'($urandom_range(16, 1));
				1: m = val_t'($urandom) & MAX_MOD;
				2: m = MAX_MOD - val_t'($urandom_range(15));
				default: m = val_t'($urandom_range(100000, 1));
			endcase
			lv = $urandom;
			rv = val_t'($urandom) & MAX_MOD;
			rm = m;
			if (kind < 60) begin
				// well-formed: moduli equal and non-zero, operands already reduced but for the value of a reduce
				if (m == 0) begin
					m = 31'd1;
					rm = m;
				end
				if (c != CMD_REDUCE) begin
					lv = 32'($unsigned(lv) % m);
				end
				rv = rv % m;
			end else if (kind < 93 && kind >= 85) begin
				rm = m ^ val_t'(1 << $urandom_range(30));
			end else if (kind >= 93) begin
				m = '0;
				rm = $urandom_range(1) ? val_t'('0) : val_t'($urandom) & MAX_MOD;
			end
			send_request(c, lv, m, rv, rm);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[modular_add_sub_mul_unit] OK");
		end else begin
			$display("[modular_add_sub_mul_unit] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
